### hdl/smbs_pkg.sv
// Shared types and constants for the sorted matrix binary search block.
// Used by smbs_engine and sorted_matrix_binary_search; depends on nothing.
package smbs_pkg;

   // Configuration registers are seven bits wide and live at two indexes.
   localparam int REG_W       = 7;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS = 1'd1;

   // Request field widths.
   localparam int INDEX_W = 12;
   localparam int VALUE_W = 32;

   // Active entry count is rows times cols, each at most seven bits.
   localparam int COUNT_W = 2 * REG_W;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   // Commands from the front end to the search engine.
   typedef struct packed {
      logic               load;      // accepted load request
      logic               search;    // accepted search request
      logic               out_free;  // result register can take a result
      logic [COUNT_W-1:0] count;     // active entry count
   } smbs_cmd_type;

   // Engine status back to the front end.
   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } smbs_status_type;

endpackage

### hdl/smbs_engine.sv
// Matrix store and binary search sequencer for the sorted matrix search block.
// Depends on smbs_pkg for the command and status structs.
module smbs_engine import smbs_pkg::*; #(
   parameter int DEPTH      = 4096,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  smbs_cmd_type                 cmd,
   input  logic [INDEX_W-1:0]           load_index,
   input  logic signed [DATA_WIDTH-1:0] value,
   output smbs_status_type              status
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic signed [DATA_WIDTH-1:0] mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;

   logic [1:0]                   state_ff, state_in;
   logic [COUNT_W-1:0]           low_ff, low_in;
   logic [COUNT_W-1:0]           high_ff, high_in;
   logic [COUNT_W-1:0]           mid_ff, mid_in;
   logic signed [DATA_WIDTH-1:0] target_ff, target_in;
   logic                         found_ff, found_in;

   logic                         mem_we;
   logic [COUNT_W:0]             bound_sum;
   logic [COUNT_W-1:0]           mid_calc;

   // The sum of the bounds carries one extra bit so the halving is exact.
   assign bound_sum = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_calc  = bound_sum[COUNT_W:1];

   // Loads beyond the active area are dropped. The active area never exceeds
   // the store depth, so an index below the count is always a legal address.
   assign mem_we = cmd.load && (COUNT_W'(load_index) < cmd.count);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ADDR_W'(load_index)] <= value;
      end
      rd_data_ff <= mem[ADDR_W'(mid_calc)];
   end

   always_comb begin
      state_in  = state_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      mid_in    = mid_ff;
      target_in = target_ff;
      found_in  = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.search) begin
               target_in = value;
               low_in    = '0;
               high_in   = cmd.count - COUNT_W'(1);
               found_in  = 1'b0;
               state_in  = (cmd.count == '0) ? ST_DONE : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            mid_in   = mid_calc;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Bounds are inclusive: the search ends once mid sits on the bound
            // that would be passed.
            if (rd_data_ff == target_ff) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (rd_data_ff < target_ff) begin
               if (mid_ff == high_ff) begin
                  state_in = ST_DONE;
               end else begin
                  low_in   = mid_ff + COUNT_W'(1);
                  state_in = ST_ISSUE;
               end
            end else begin
               if (mid_ff == low_ff) begin
                  state_in = ST_DONE;
               end else begin
                  high_in  = mid_ff - COUNT_W'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_DONE: begin
            if (cmd.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff    <= low_in;
      high_ff   <= high_in;
      mid_ff    <= mid_in;
      target_ff <= target_in;
      found_ff  <= found_in;
   end

   assign status.busy  = (state_ff != ST_IDLE);
   assign status.done  = (state_ff == ST_DONE);
   assign status.found = found_ff;

endmodule

### hdl/sorted_matrix_binary_search.sv
// Sorted matrix binary search: request decode, configuration and result stage.
// Depends on smbs_pkg and instantiates smbs_engine.
// Operation: a load request gives no response. A search makes P probes, where P is
//   at most ceil(log2(rows * cols + 1)), and then presents a response.
// Throughput: one request at a time; each probe is one synchronous store read
//   followed by one compare. A finished search holds the block until the response
//   register can take it; the next request can be taken as the response appears.
//   Synchronous reset clears control and sets 64x64.
module sorted_matrix_binary_search import smbs_pkg::*; #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [VALUE_W-1:0] req_data_value,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,

   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [REG_W-1:0]          csr_write_data
);

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int REG_MAX = (1 << REG_W) - 1;
   // Saturation values; when a limit exceeds the register range the register
   // can never pass it, so the cap is then never selected.
   localparam int ROWS_CAP = (MAX_ROWS > REG_MAX) ? REG_MAX : MAX_ROWS;
   localparam int COLS_CAP = (MAX_COLS > REG_MAX) ? REG_MAX : MAX_COLS;

   logic [REG_W-1:0] rows_ff, rows_in;
   logic [REG_W-1:0] cols_ff, cols_in;
   logic [REG_W-1:0] rows_sat;
   logic [REG_W-1:0] cols_sat;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;

   logic             req_accept;
   logic             out_free;

   logic signed [DATA_WIDTH-1:0] req_value;

   smbs_cmd_type     eng_cmd;
   smbs_status_type  eng_status;

   // Configuration writes. The registers keep the written value; saturation
   // against the build limits is applied where the count is formed.
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_write_data;
            CSR_COLS: cols_in = csr_write_data;
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= REG_W'(64);
         cols_ff <= REG_W'(64);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign rows_sat = (int'(rows_ff) > MAX_ROWS) ? REG_W'(ROWS_CAP) : rows_ff;
   assign cols_sat = (int'(cols_ff) > MAX_COLS) ? REG_W'(COLS_CAP) : cols_ff;

   // The engine runs one request at a time. A load is written into the store
   // at the edge that accepts it, so a search right behind it sees the data.
   assign req_ready  = !eng_status.busy;
   assign req_accept = req_valid && req_ready;

   // The request value is sign-extended or truncated to the store width.
   assign req_value = DATA_WIDTH'(req_data_value);

   // A finished search moves into the response register when that register is
   // empty or being drained in the same cycle; otherwise the engine holds.
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign eng_cmd.load     = req_accept && (req_action == ACTION_LOAD);
   assign eng_cmd.search   = req_accept && (req_action == ACTION_SEARCH);
   assign eng_cmd.out_free = out_free;
   assign eng_cmd.count    = COUNT_W'(rows_sat) * COUNT_W'(cols_sat);

   smbs_engine #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (eng_cmd),
      .load_index (req_entry_index),
      .value      (req_value),
      .status     (eng_status)
   );

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      if (eng_status.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = eng_status.found;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

`ifndef SYNTHESIS
   // A search in flight keeps the request side closed.
   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ACTION_SEARCH) |=> !req_ready)
      else $error("request accepted while a search was in flight");

   // A load never occupies the engine beyond its own cycle.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ACTION_LOAD) |=> req_ready)
      else $error("load request left the engine busy");

   // A new response only appears after the engine reported a finished search.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(eng_status.done))
      else $error("response raised without a finished search");

   // A finished search that waits on the response register stays finished.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (eng_status.done && !out_free) |=> eng_status.done)
      else $error("finished search dropped before the response was stored");
`endif

endmodule
